// ===== sv/tet_pkg.sv =====
// shared types and constants for the tcp exchange tracker
package tet_pkg;

  localparam int IN_TDATA_W  = 184;
  localparam int IN_TUSER_W  = 1;
  localparam int OUT_TDATA_W = 40;
  localparam int OUT_TUSER_W = 3;

  // event codes on the result channel
  typedef enum logic [2:0] {
    EV_REJECT  = 3'd0,
    EV_SYN     = 3'd1,
    EV_SYNACK  = 3'd2,
    EV_ACK     = 3'd3,
    EV_REQUEST = 3'd4,
    EV_DATA    = 3'd5,
    EV_FINAL   = 3'd6
  } ev_t;

  // header after classification by the front end
  typedef struct packed {
    logic        is_tcp;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [31:0] seq_num;
    logic [31:0] ack_num;
    logic [15:0] payload_len;
    logic        psh;
    logic        fin;
    logic        pure_syn;    // syn only, no payload
    logic        synack_pat;  // syn+ack only, no payload
    logic        ack_pat;     // ack only, no payload
    logic        req_pat;     // ack+psh, no syn/fin, payload
    logic        srv_pat;     // ack, no syn, payload
  } item_t;

endpackage

// ===== sv/tcp_exchange_tracker_top.sv =====
// top level of the tcp exchange tracker
// usage:
//   in_* carries one parsed tcp header per item; out_* returns one result
//   item for every input item, in order, saying whether the header advanced
//   the tracked exchange (syn, syn-ack, ack, request, data, final segment)
//   and whether its payload should be stored under its sequence number
// path: an accepted item passes through the front register and a queue
//   slot, and the queue slot is read straight into the result register
// throughput: one item per cycle while out_tready is high; the state update is two
//   adds and a set of 16- and 32-bit compares in the back-end cycle, so nothing iterates
// stalls: the queue of FIFO_DEPTH items sits between the decode stage and
//   the state machine, and the result register is refilled in the same
//   cycle it is drained, so out_tready low only backs up the queue and
//   in_tready falls once the queue and front register are full
// reset: a synchronous rst_n low clears the stage to idle and empties the
//   queue and result register; the endpoint tuple is captured again by the
//   next pure syn
// after the final segment the tracker stays sealed and rejects every item
//   until reset
module tcp_exchange_tracker_top import tet_pkg::*; #(
  parameter int FIFO_DEPTH = 4
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_tvalid,
  output logic                    in_tready,
  // src_addr, dst_addr, src_port, dst_port, seq_num, ack_num, flag_syn,
  // flag_ack, flag_psh, flag_fin, payload_len, zero pad
  input  logic [IN_TDATA_W-1:0]   in_tdata,
  // is_tcp
  input  logic [IN_TUSER_W-1:0]   in_tuser,
  output logic                    out_tvalid,
  input  logic                    out_tready,
  // accepted, store_segment, segment_seq, exchange_done, zero pad
  output logic [OUT_TDATA_W-1:0]  out_tdata,
  // event_res
  output logic [OUT_TUSER_W-1:0]  out_tuser
);

  logic  push_valid, push_ready;
  item_t push_item;
  logic  pop_valid, pop_ready;
  item_t pop_item;

  // decode flag patterns once, off the state path
  tet_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_data    (in_tdata),
    .in_user    (in_tuser),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  // decouples decode from the state machine
  tet_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  // per-stage checks, tuple match and the result register
  tet_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_item  (pop_item),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata),
    .out_user  (out_tuser)
  );

endmodule

// ===== sv/tet_front.sv =====
// front end: accepts header items, decodes flag patterns, hands them to the queue
module tet_front import tet_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [IN_TDATA_W-1:0]  in_data,
  input  logic [IN_TUSER_W-1:0]  in_user,
  output logic                   push_valid,
  input  logic                   push_ready,
  output item_t                  push_item
);

  logic  valid_r, valid_nxt;
  item_t item_r, item_nxt;
  logic  syn, fack, psh, fin, len_nz;
  logic [15:0] len;

  assign syn    = in_data[160];
  assign fack   = in_data[161];
  assign psh    = in_data[162];
  assign fin    = in_data[163];
  assign len    = in_data[179:164];
  assign len_nz = |len;

  assign in_ready   = !valid_r || push_ready;
  assign push_valid = valid_r;
  assign push_item  = item_r;

  always_comb begin
    item_nxt.is_tcp      = in_user[0];
    item_nxt.src_addr    = in_data[31:0];
    item_nxt.dst_addr    = in_data[63:32];
    item_nxt.src_port    = in_data[79:64];
    item_nxt.dst_port    = in_data[95:80];
    item_nxt.seq_num     = in_data[127:96];
    item_nxt.ack_num     = in_data[159:128];
    item_nxt.payload_len = len;
    item_nxt.psh         = psh;
    item_nxt.fin         = fin;
    item_nxt.pure_syn    = syn && !fack && !psh && !fin && !len_nz;
    item_nxt.synack_pat  = syn && fack && !psh && !fin && !len_nz;
    item_nxt.ack_pat     = !syn && fack && !psh && !fin && !len_nz;
    item_nxt.req_pat     = !syn && fack && psh && !fin && len_nz;
    item_nxt.srv_pat     = !syn && fack && len_nz;
  end

  always_comb begin
    valid_nxt = valid_r;
    if (in_ready) begin
      valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    if (in_valid && in_ready) begin
      item_r <= item_nxt;
    end
  end

endmodule

// ===== sv/tet_fifo.sv =====
// short queue of classified items between front and back
module tet_fifo import tet_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push_valid,
  output logic  push_ready,
  input  item_t push_item,
  output logic  pop_valid,
  input  logic  pop_ready,
  output item_t pop_item
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  item_t            slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_item   = slots[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (do_push) begin
      slots[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== sv/tet_back.sv =====
// back end: connection state machine and result register
module tet_back import tet_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    pop_valid,
  output logic                    pop_ready,
  input  item_t                   pop_item,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [OUT_TDATA_W-1:0]  out_data,
  output logic [OUT_TUSER_W-1:0]  out_user
);

  typedef enum logic [2:0] {
    ST_IDLE       = 3'd0,
    ST_SYN_SEEN   = 3'd1,
    ST_SYNACK_SEEN = 3'd2,
    ST_ACK_SEEN   = 3'd3,
    ST_REQ_SEEN   = 3'd4,
    ST_DONE       = 3'd5
  } stage_t;

  stage_t      stage_r, stage_nxt;
  logic [31:0] track_seq_r, track_seq_nxt;
  logic [31:0] track_ack_r, track_ack_nxt;
  logic [31:0] srv_addr_r, srv_addr_nxt;
  logic [31:0] cli_addr_r, cli_addr_nxt;
  logic [15:0] srv_port_r, srv_port_nxt;
  logic [15:0] cli_port_r, cli_port_nxt;

  logic        out_valid_r, out_valid_nxt;
  ev_t         ev_r, ev_nxt;
  logic        store_r, store_nxt;
  logic [31:0] seg_seq_r, seg_seq_nxt;
  logic        done_r, done_nxt;

  logic        take;
  logic        to_server, to_client, tuple_ok;
  logic [31:0] seq_inc;

  assign pop_ready = !out_valid_r || out_ready;
  assign take      = pop_valid && pop_ready;
  assign out_valid = out_valid_r;

  // result fields, lowest bit up: accepted, store_segment, segment_seq, exchange_done
  assign out_data = {5'd0, done_r, seg_seq_r, store_r, (ev_r != EV_REJECT)};
  assign out_user = ev_r;

  assign seq_inc   = track_seq_r + 32'd1;
  assign to_server = srv_addr_r == pop_item.dst_addr && cli_addr_r == pop_item.src_addr &&
                     srv_port_r == pop_item.dst_port && cli_port_r == pop_item.src_port;
  assign to_client = cli_addr_r == pop_item.dst_addr && srv_addr_r == pop_item.src_addr &&
                     cli_port_r == pop_item.dst_port && srv_port_r == pop_item.src_port;
  assign tuple_ok  = to_server || to_client;

  always_comb begin
    stage_nxt     = stage_r;
    track_seq_nxt = track_seq_r;
    track_ack_nxt = track_ack_r;
    srv_addr_nxt  = srv_addr_r;
    cli_addr_nxt  = cli_addr_r;
    srv_port_nxt  = srv_port_r;
    cli_port_nxt  = cli_port_r;
    ev_nxt        = EV_REJECT;
    store_nxt     = 1'b0;
    seg_seq_nxt   = '0;
    done_nxt      = 1'b0;
    if (pop_item.is_tcp) begin
      case (stage_r)
        ST_IDLE: begin
          if (pop_item.pure_syn) begin
            stage_nxt     = ST_SYN_SEEN;
            track_seq_nxt = pop_item.seq_num;
            srv_addr_nxt  = pop_item.dst_addr;
            cli_addr_nxt  = pop_item.src_addr;
            srv_port_nxt  = pop_item.dst_port;
            cli_port_nxt  = pop_item.src_port;
            ev_nxt        = EV_SYN;
          end
        end
        ST_SYN_SEEN: begin
          if (tuple_ok && pop_item.synack_pat && cli_addr_r == pop_item.dst_addr &&
              pop_item.ack_num == seq_inc) begin
            stage_nxt     = ST_SYNACK_SEEN;
            track_ack_nxt = pop_item.ack_num;
            track_seq_nxt = pop_item.seq_num;
            ev_nxt        = EV_SYNACK;
          end
        end
        ST_SYNACK_SEEN: begin
          if (tuple_ok && pop_item.ack_pat && srv_addr_r == pop_item.dst_addr &&
              pop_item.ack_num == seq_inc && track_ack_r == pop_item.seq_num) begin
            stage_nxt     = ST_ACK_SEEN;
            track_seq_nxt = seq_inc;
            ev_nxt        = EV_ACK;
          end
        end
        ST_ACK_SEEN: begin
          if (tuple_ok && pop_item.req_pat && srv_addr_r == pop_item.dst_addr &&
              track_seq_r == pop_item.ack_num && track_ack_r == pop_item.seq_num) begin
            stage_nxt     = ST_REQ_SEEN;
            track_ack_nxt = track_ack_r + {16'd0, pop_item.payload_len};
            track_seq_nxt = pop_item.ack_num;
            ev_nxt        = EV_REQUEST;
          end
        end
        ST_REQ_SEEN: begin
          if (tuple_ok && pop_item.srv_pat && cli_addr_r == pop_item.dst_addr &&
              track_ack_r == pop_item.ack_num) begin
            // a segment without fin is plain data, even when pushed
            if (!pop_item.fin) begin
              ev_nxt      = EV_DATA;
              store_nxt   = 1'b1;
              seg_seq_nxt = pop_item.seq_num;
            end else if (pop_item.psh) begin
              stage_nxt   = ST_DONE;
              ev_nxt      = EV_FINAL;
              store_nxt   = 1'b1;
              seg_seq_nxt = pop_item.seq_num;
              done_nxt    = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (pop_ready) begin
      out_valid_nxt = pop_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (take) begin
        stage_r <= stage_nxt;
      end
    end
    if (take) begin
      track_seq_r <= track_seq_nxt;
      track_ack_r <= track_ack_nxt;
      srv_addr_r  <= srv_addr_nxt;
      cli_addr_r  <= cli_addr_nxt;
      srv_port_r  <= srv_port_nxt;
      cli_port_r  <= cli_port_nxt;
      ev_r        <= ev_nxt;
      store_r     <= store_nxt;
      seg_seq_r   <= seg_seq_nxt;
      done_r      <= done_nxt;
    end
  end

endmodule
